// ===== rtl/core/quantized_conv_mac_core_macros.svh =====
// Assertion helpers used by the core RTL.
`ifndef QUANTIZED_CONV_MAC_CORE_MACROS_SVH
`define QUANTIZED_CONV_MAC_CORE_MACROS_SVH

// Clocked implication check, off while reset is asserted.
`define CMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never hold once out of reset.
`define CMC_NEVER(lbl, cond, msg) \
    `CMC_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/core/cmc_pkg.sv =====
`timescale 1ns / 1ps

package cmc_pkg;

    localparam int DATA_W     = 32;
    localparam int ACC_W      = 64;
    localparam int FRAC_IN    = 16;
    localparam int INT_W      = 4;
    localparam int FRAC_W     = 5;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ACT_INT  = 3'd0,
        CFG_ACT_FRAC = 3'd1,
        CFG_WGT_INT  = 3'd2,
        CFG_WGT_FRAC = 3'd3,
        CFG_RELU     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [INT_W-1:0]  int_bits;
        logic [FRAC_W-1:0] frac_bits;
    } t_qfmt;

    localparam logic [INT_W-1:0]  RST_INT_BITS  = 4'd4;
    localparam logic [FRAC_W-1:0] RST_FRAC_BITS = 5'd12;
    localparam logic              RST_RELU      = 1'b1;

endpackage

// ===== rtl/core/cmc_quant.sv =====
`timescale 1ns / 1ps

// Registered quantiser: truncate Q16.16 toward zero to the kept fraction bits,
// then saturate to the signed format. Output stays in Q16.16 units.
module cmc_quant (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [cmc_pkg::DATA_W-1:0]   i_x,
    input  cmc_pkg::t_qfmt                      i_fmt,
    output logic signed [cmc_pkg::DATA_W-1:0]   o_q
);

    logic [cmc_pkg::INT_W-1:0]  ibits;
    logic [cmc_pkg::FRAC_W-1:0] fbits;
    logic [cmc_pkg::FRAC_W-1:0] shamt;
    logic [cmc_pkg::FRAC_W-1:0] lexp;
    logic [cmc_pkg::DATA_W:0]   mask;
    logic [cmc_pkg::DATA_W:0]   limit;
    logic [cmc_pkg::DATA_W:0]   tsum;
    logic [cmc_pkg::DATA_W:0]   trunc;
    logic [cmc_pkg::DATA_W:0]   n_q;
    logic signed [cmc_pkg::DATA_W-1:0] r_q;

    always_comb begin
        ibits = (i_fmt.int_bits == '0) ? 4'd1 : i_fmt.int_bits;
        fbits = (i_fmt.frac_bits > 5'(cmc_pkg::FRAC_IN)) ? 5'(cmc_pkg::FRAC_IN)
                                                          : i_fmt.frac_bits;
        shamt = 5'(cmc_pkg::FRAC_IN) - fbits;
        // saturation bound in Q16.16 units is 2^(ibits+15)
        lexp  = 5'(ibits) + 5'd15;
        mask  = (33'd1 << shamt) - 33'd1;
        limit = 33'd1 << lexp;
        // negatives round up (toward zero) by adding the dropped-bit mask first
        tsum  = {i_x[cmc_pkg::DATA_W-1], i_x} + (i_x[cmc_pkg::DATA_W-1] ? mask : 33'd0);
        trunc = tsum & ~mask;
        if ($signed(trunc) >= $signed(limit)) begin
            n_q = limit - mask - 33'd1;
        end else if ($signed(trunc) < -$signed(limit)) begin
            n_q = -limit;
        end else begin
            n_q = trunc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= signed'(n_q[cmc_pkg::DATA_W-1:0]);
        end
    end

    assign o_q = r_q;

endmodule

// ===== rtl/core/quantized_conv_mac_core.sv =====
`timescale 1ns / 1ps
// Only a term marked last gives a result word.
// Throughput: one term per cycle; the five-stage pipe (input, quantise, multiply,
// bias align, accumulate) stalls only when a last term meets an unread output word.
// Reset (synchronous, active low): pipe and output empty, accumulator zero,
// formats back to 4 integer and 12 fraction bits, ReLU on.
module quantized_conv_mac_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [cmc_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [cmc_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [cmc_pkg::DATA_W-1:0]     i_activation,
    input  logic signed [cmc_pkg::DATA_W-1:0]     i_weight,
    input  logic signed [cmc_pkg::DATA_W-1:0]     i_bias_value,
    input  logic                                  i_last_term,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [cmc_pkg::ACC_W-1:0]      o_result
);

`include "quantized_conv_mac_core_macros.svh"

    cmc_pkg::t_qfmt r_act_fmt;
    cmc_pkg::t_qfmt r_wgt_fmt;
    logic           r_relu_en;

    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_out_v;
    logic s1_ready, s2_ready, s3_ready, s4_ready, s4_take;

    logic signed [cmc_pkg::DATA_W-1:0] r_s1_act, r_s1_wgt, r_s1_bias;
    logic                              r_s1_last;
    logic signed [cmc_pkg::DATA_W-1:0] s2_qa, s2_qw, r_s2_bias;
    logic                              r_s2_last;
    logic signed [cmc_pkg::ACC_W-1:0]  prod_c, r_s3_prod;
    logic signed [cmc_pkg::DATA_W-1:0] r_s3_bias;
    logic                              r_s3_last;
    logic signed [cmc_pkg::ACC_W-1:0]  bias_al, r_s4_add;
    logic                              r_s4_last;
    logic signed [cmc_pkg::ACC_W-1:0]  r_acc, n_acc, r_result;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_fmt <= '{int_bits: cmc_pkg::RST_INT_BITS, frac_bits: cmc_pkg::RST_FRAC_BITS};
            r_wgt_fmt <= '{int_bits: cmc_pkg::RST_INT_BITS, frac_bits: cmc_pkg::RST_FRAC_BITS};
            r_relu_en <= cmc_pkg::RST_RELU;
        end else if (i_cfg_we) begin
            unique case (cmc_pkg::t_cfg_idx'(i_cfg_addr))
                cmc_pkg::CFG_ACT_INT:  r_act_fmt.int_bits  <= i_cfg_wdata[cmc_pkg::INT_W-1:0];
                cmc_pkg::CFG_ACT_FRAC: r_act_fmt.frac_bits <= i_cfg_wdata;
                cmc_pkg::CFG_WGT_INT:  r_wgt_fmt.int_bits  <= i_cfg_wdata[cmc_pkg::INT_W-1:0];
                cmc_pkg::CFG_WGT_FRAC: r_wgt_fmt.frac_bits <= i_cfg_wdata;
                cmc_pkg::CFG_RELU:     r_relu_en           <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // a last term can only leave stage 4 when the output register is free
    assign s4_take  = r_s4_v && (!r_s4_last || !r_out_v || i_out_ready);
    assign s4_ready = !r_s4_v || s4_take;
    assign s3_ready = !r_s3_v || s4_ready;
    assign s2_ready = !r_s2_v || s3_ready;
    assign s1_ready = !r_s1_v || s2_ready;
    assign o_in_ready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_acc   <= '0;
        end else begin
            if (s1_ready) r_s1_v <= i_in_valid;
            if (s2_ready) r_s2_v <= r_s1_v;
            if (s3_ready) r_s3_v <= r_s2_v;
            if (s4_ready) r_s4_v <= r_s3_v;
            if (s4_take) begin
                r_acc <= r_s4_last ? '0 : n_acc;
            end
            if (s4_take && r_s4_last) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r_s1_act  <= i_activation;
            r_s1_wgt  <= i_weight;
            r_s1_bias <= i_bias_value;
            r_s1_last <= i_last_term;
        end
        if (s2_ready) begin
            r_s2_bias <= r_s1_bias;
            r_s2_last <= r_s1_last;
        end
        if (s3_ready) begin
            r_s3_prod <= prod_c;
            r_s3_bias <= r_s2_bias;
            r_s3_last <= r_s2_last;
        end
        if (s4_ready) begin
            r_s4_add  <= r_s3_prod + (r_s3_last ? bias_al : 64'sd0);
            r_s4_last <= r_s3_last;
        end
        if (s4_take && r_s4_last) begin
            r_result <= (r_relu_en && n_acc[cmc_pkg::ACC_W-1]) ? '0 : n_acc;
        end
    end

    cmc_quant u_quant_act (
        .i_clk (i_clk),
        .i_en  (s2_ready),
        .i_x   (r_s1_act),
        .i_fmt (r_act_fmt),
        .o_q   (s2_qa)
    );

    cmc_quant u_quant_wgt (
        .i_clk (i_clk),
        .i_en  (s2_ready),
        .i_x   (r_s1_wgt),
        .i_fmt (r_wgt_fmt),
        .o_q   (s2_qw)
    );

    // both operands are Q16.16 units, so the product lands in Q32.32
    assign prod_c  = 64'(s2_qa) * 64'(s2_qw);
    assign bias_al = {{(cmc_pkg::ACC_W-cmc_pkg::DATA_W-cmc_pkg::FRAC_IN)
                       {r_s3_bias[cmc_pkg::DATA_W-1]}},
                      r_s3_bias, {cmc_pkg::FRAC_IN{1'b0}}};
    assign n_acc   = r_acc + r_s4_add;

    assign o_out_valid = r_out_v;
    assign o_result    = r_result;

    `CMC_ASSERT(a_acc_clear, (s4_take && r_s4_last) |=> (r_acc == '0), "accumulator not cleared after last term")
    `CMC_NEVER(a_relu_sign, r_out_v && r_relu_en && r_result[cmc_pkg::ACC_W-1], "negative word with ReLU on")
    `CMC_ASSERT(a_stall_full, !o_in_ready |-> (r_s1_v && r_s2_v && r_s3_v && r_s4_v && r_out_v), "input stalled with a bubble in the pipe")
    `CMC_ASSERT(a_out_src, $rose(o_out_valid) |-> $past(r_s4_v && r_s4_last), "output word without a last term")

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic signed [cmc_pkg::DATA_W-1:0] act;
        logic signed [cmc_pkg::DATA_W-1:0] wgt;
        logic signed [cmc_pkg::DATA_W-1:0] bias;
        logic                              last;
    } t_mac_term;

    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 12;

    logic                               i_clk        = 1'b0;
    logic                               i_rst_n      = 1'b0;
    logic                               i_cfg_we     = 1'b0;
    logic [cmc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr   = '0;
    logic [cmc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata  = '0;
    logic                               i_in_valid   = 1'b0;
    logic                               o_in_ready;
    logic signed [cmc_pkg::DATA_W-1:0]  i_activation = '0;
    logic signed [cmc_pkg::DATA_W-1:0]  i_weight     = '0;
    logic signed [cmc_pkg::DATA_W-1:0]  i_bias_value = '0;
    logic                               i_last_term  = 1'b0;
    logic                               o_out_valid;
    logic                               i_out_ready  = 1'b0;
    logic signed [cmc_pkg::ACC_W-1:0]   o_result;

    quantized_conv_mac_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_activation (i_activation),
        .i_weight     (i_weight),
        .i_bias_value (i_bias_value),
        .i_last_term  (i_last_term),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (o_result)
    );

    // shadow copy of the format registers
    logic [cmc_pkg::INT_W-1:0]  m_act_int  = cmc_pkg::RST_INT_BITS;
    logic [cmc_pkg::FRAC_W-1:0] m_act_frac = cmc_pkg::RST_FRAC_BITS;
    logic [cmc_pkg::INT_W-1:0]  m_wgt_int  = cmc_pkg::RST_INT_BITS;
    logic [cmc_pkg::FRAC_W-1:0] m_wgt_frac = cmc_pkg::RST_FRAC_BITS;
    logic                       m_relu     = cmc_pkg::RST_RELU;
    logic [cmc_pkg::ACC_W-1:0]  mac_sum    = '0;

    t_mac_term                  pending_terms[$];
    logic [cmc_pkg::ACC_W-1:0]  due_results[$];
    t_mac_term                  cur_term;
    logic [cmc_pkg::ACC_W-1:0]  want;
    int                         terms_queued = 0;
    int                         terms_taken  = 0;
    int                         mismatches   = 0;
    int                         quiet_cycles = 0;
    bit                         calm         = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Truncate toward zero, then saturate; result stays in units of 2^-16.
    function automatic longint quantise(logic signed [cmc_pkg::DATA_W-1:0] x,
                                        logic [cmc_pkg::INT_W-1:0] ib,
                                        logic [cmc_pkg::FRAC_W-1:0] fb);
        int unsigned f, ibits, s, mag;
        longint v, hi, lo, q;
        f     = (fb > cmc_pkg::FRAC_IN) ? cmc_pkg::FRAC_IN : fb;
        ibits = (ib < 1) ? 1 : ib;
        s     = cmc_pkg::FRAC_IN - f;
        mag   = ibits - 1 + f;
        hi    = (longint'(1) << mag) - 1;
        lo    = -hi - 1;
        v     = x;
        q     = (v >= 0) ? (v >>> s) : -((-v) >>> s);
        if (q > hi) q = hi;
        if (q < lo) q = lo;
        return q * (longint'(1) << s);
    endfunction

    function automatic void accumulate_term(t_mac_term t);
        longint                    prod;
        logic [cmc_pkg::ACC_W-1:0] total;
        prod = quantise(t.act, m_act_int, m_act_frac) * quantise(t.wgt, m_wgt_int, m_wgt_frac);
        mac_sum += prod;
        if (t.last) begin
            total = mac_sum + (longint'(t.bias) << cmc_pkg::FRAC_IN);
            if (m_relu && total[cmc_pkg::ACC_W-1]) total = '0;
            due_results.push_back(total);
            mac_sum = '0;
        end
    endfunction

    function automatic logic [cmc_pkg::DATA_W-1:0] pick_operand();
        logic [cmc_pkg::DATA_W-1:0] v;
        int                         k;
        case ($urandom_range(0, 9))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = '0;
            3: v = $urandom_range(0, 32'h3_FFFF);
            4, 5, 6: begin
                k = $urandom_range(0, 31);
                v = $urandom & ((32'd1 << k) - 1);
            end
            default: v = $urandom;
        endcase
        if ($urandom_range(0, 9) < 3 && v != 32'h8000_0000) v = -v;
        return v;
    endfunction

    task automatic queue_term(logic [cmc_pkg::DATA_W-1:0] act, logic [cmc_pkg::DATA_W-1:0] wgt,
                              logic [cmc_pkg::DATA_W-1:0] bias, logic last);
        t_mac_term t;
        t.act  = act;
        t.wgt  = wgt;
        t.bias = bias;
        t.last = last;
        pending_terms.push_back(t);
        terms_queued++;
    endtask

    task automatic write_reg(cmc_pkg::t_cfg_idx idx, logic [cmc_pkg::CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        case (idx)
            cmc_pkg::CFG_ACT_INT:  m_act_int  = val[cmc_pkg::INT_W-1:0];
            cmc_pkg::CFG_ACT_FRAC: m_act_frac = val[cmc_pkg::FRAC_W-1:0];
            cmc_pkg::CFG_WGT_INT:  m_wgt_int  = val[cmc_pkg::INT_W-1:0];
            cmc_pkg::CFG_WGT_FRAC: m_wgt_frac = val[cmc_pkg::FRAC_W-1:0];
            cmc_pkg::CFG_RELU:     m_relu     = val[0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [cmc_pkg::CFG_DATA_W-1:0] ai,
                             logic [cmc_pkg::CFG_DATA_W-1:0] af,
                             logic [cmc_pkg::CFG_DATA_W-1:0] wi,
                             logic [cmc_pkg::CFG_DATA_W-1:0] wf,
                             logic [cmc_pkg::CFG_DATA_W-1:0] relu);
        write_reg(cmc_pkg::CFG_ACT_INT, ai);
        write_reg(cmc_pkg::CFG_ACT_FRAC, af);
        write_reg(cmc_pkg::CFG_WGT_INT, wi);
        write_reg(cmc_pkg::CFG_WGT_FRAC, wf);
        write_reg(cmc_pkg::CFG_RELU, relu);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // wait for every word in and out, then let the pipe empty
    task automatic drain();
        while (!(terms_taken == terms_queued && due_results.size() == 0))
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int len, n;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset formats: saturation both ways, ReLU on negative, zero and positive sums
        queue_term(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1);
        queue_term(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        queue_term(32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000, 1'b1);
        queue_term(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
        queue_term(32'h0001_8000, 32'hFFFE_7FFF, 32'h0000_0000, 1'b0);
        queue_term(32'hFFFF_0001, 32'h0000_0001, 32'h0000_0100, 1'b1);
        drain();

        // zero integer bits, over-wide fraction, wide integer, ReLU off
        configure(5'd0, 5'd31, 5'd15, 5'd17, 5'd0);
        queue_term(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b1);
        queue_term(32'hFFFF_8000, 32'h1234_5678, 32'h8000_0000, 1'b1);
        queue_term(32'h0000_7FFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        drain();

        // widest format: nine full-scale products wrap the accumulator
        configure(5'd15, 5'd16, 5'd15, 5'd16, 5'd0);
        for (int k = 0; k < 9; k++)
            queue_term(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, k == 8);
        drain();

        // narrowest legal format
        configure(5'd1, 5'd0, 5'd1, 5'd0, 5'd1);
        queue_term(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b1);
        queue_term(32'h0001_8000, 32'h0001_0000, 32'h0000_0000, 1'b1);
        drain();

        for (int p = 0; p < 10; p++) begin
            if (p == 0)
                configure(5'd1, 5'd0, 5'd1, 5'd0, 5'($urandom_range(0, 31)));
            else if (p == 1)
                configure(5'd8, 5'd16, 5'd8, 5'd16, 5'($urandom_range(0, 31)));
            else
                configure(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                          5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                          5'($urandom_range(0, 31)));
            calm = (p == 4);
            n = 0;
            while (n < 165) begin
                case ($urandom_range(0, 19))
                    0, 1:    len = 1;
                    2, 3, 4: len = $urandom_range(13, 40);
                    default: len = $urandom_range(2, 12);
                endcase
                for (int k = 0; k < len; k++)
                    queue_term(pick_operand(), pick_operand(), pick_operand(), k == len - 1);
                n += len;
            end
            drain();
            calm = 1'b0;
        end

        if (mismatches == 0 && due_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                accumulate_term(cur_term);
                terms_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_terms.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
                    cur_term = pending_terms.pop_front();
                    i_activation <= cur_term.act;
                    i_weight     <= cur_term.wgt;
                    i_bias_value <= cur_term.bias;
                    i_last_term  <= cur_term.last;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %h", o_result);
                end else begin
                    want = due_results.pop_front();
                    if (o_result !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %h, got %h", want, o_result);
                    end
                end
            end
            i_out_ready <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    // watchdog: no word moving on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cmc_pkg.sv
rtl/core/cmc_quant.sv
rtl/core/quantized_conv_mac_core.sv
tb/sv/tb.sv
